/* rtl/rcpwm_pkg.sv */
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared types, constants and helper functions for the rc pwm pulse decoder.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

    // counter width of the pulse timers
    localparam int CNT_W   = 16;
    localparam int CMP_W   = (CNT_W > 16) ? CNT_W : 16;
    localparam int N_LINES = 5;

    // line positions within pin_levels
    localparam int LINE_ROLL   = 0;
    localparam int LINE_THRUST = 1;
    localparam int LINE_PITCH  = 2;
    localparam int LINE_YAW    = 3;
    localparam int LINE_EMG    = 4;
    localparam int N_GROUP     = 4;

    // conversion constants
    localparam int ANGLE_SHIFT  = 5;
    localparam int THRUST_SHIFT = 2;
    localparam int ANGLE_W      = 11;
    localparam int THRUST_W     = 14;
    localparam int ANGLE_OUT_W  = 12;

    // configuration register indexes
    localparam logic [1:0] CFG_FS_THR    = 2'd0;
    localparam logic [1:0] CFG_BRAKE_THR = 2'd1;
    localparam logic [1:0] CFG_FS_THRUST = 2'd2;
    localparam logic [1:0] CFG_ANG_OFS   = 2'd3;

    // configuration reset values
    localparam logic [15:0]         RST_FS_THR    = 16'd4500;
    localparam logic [15:0]         RST_BRAKE_THR = 16'd7500;
    localparam logic [THRUST_W-1:0] RST_FS_THRUST = 14'd1000;
    localparam logic [ANGLE_W-1:0]  RST_ANG_OFS   = 11'd187;

    // emergency codes
    localparam logic [1:0] EMG_NORMAL   = 2'd0;
    localparam logic [1:0] EMG_FAILSAFE = 2'd1;
    localparam logic [1:0] EMG_BRAKE    = 2'd2;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [N_LINES-1:0][CNT_W-1:0] t_widths;

    typedef struct packed {
        logic [4:0] pin_levels;
        logic       report;
    } t_in_word;

    typedef struct packed {
        logic signed [ANGLE_OUT_W-1:0] roll_angle;
        logic signed [ANGLE_OUT_W-1:0] pitch_angle;
        logic signed [ANGLE_OUT_W-1:0] yaw_angle;
        logic        [THRUST_W-1:0]    thrust_out;
        logic        [1:0]             emergency_code;
    } t_out_word;

    typedef struct packed {
        logic [15:0]         fs_thr;
        logic [15:0]         brake_thr;
        logic [THRUST_W-1:0] fs_thrust;
        logic [ANGLE_W-1:0]  ang_ofs;
    } t_cfg;

    // width >> 5, saturated to the angle range
    function automatic logic [ANGLE_W-1:0] sat_angle(input t_count w);
        t_count s;
        s = w >> ANGLE_SHIFT;
        if (CMP_W'(s) > CMP_W'({ANGLE_W{1'b1}}))
            return {ANGLE_W{1'b1}};
        else
            return ANGLE_W'(s);
    endfunction

    // width >> 2, saturated to the thrust range
    function automatic logic [THRUST_W-1:0] sat_thrust(input t_count w);
        t_count s;
        s = w >> THRUST_SHIFT;
        if (CMP_W'(s) > CMP_W'({THRUST_W{1'b1}}))
            return {THRUST_W{1'b1}};
        else
            return THRUST_W'(s);
    endfunction

endpackage

/* rtl/rc_pwm_pulse_decoder_top.sv */
// ----------------------------------------------------------------------------
// rc_pwm_pulse_decoder_top
// Pulse-width capture of five receiver lines with a converted report word.
// ----------------------------------------------------------------------------
// One input word is one timer tick and is taken every clock while the output
// side keeps up. Five lanes detect edges in parallel; the four control lines
// share one saturating timer, the emergency line has its own. A word with the
// report bit set yields one result word, written into a two-entry output
// buffer at the edge that accepts it and visible in the next cycle. The input
// stalls only while that buffer is full, so sustained rate is one word per
// clock while the output side keeps up.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_decoder_top
    import rcpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    input  t_in_word    i_in_word,
    output logic        o_in_stall,
    // output channel
    output logic        o_out_valid,
    output t_out_word   o_out_word,
    input  logic        i_out_stall,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg               r_cfg;
    logic               accept;
    logic [N_LINES-1:0] rise;
    t_count             grp_count;
    t_count             emg_count;
    t_widths            width_next;
    t_out_word          result;

    t_out_word          r_buf [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_fill;
    logic               push;
    logic               pop;

    assign accept = i_in_valid & ~o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fs_thr    <= RST_FS_THR;
            r_cfg.brake_thr <= RST_BRAKE_THR;
            r_cfg.fs_thrust <= RST_FS_THRUST;
            r_cfg.ang_ofs   <= RST_ANG_OFS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FS_THR:    r_cfg.fs_thr    <= i_cfg_wdata;
                CFG_BRAKE_THR: r_cfg.brake_thr <= i_cfg_wdata;
                CFG_FS_THRUST: r_cfg.fs_thrust <= i_cfg_wdata[THRUST_W-1:0];
                CFG_ANG_OFS:   r_cfg.ang_ofs   <= i_cfg_wdata[ANGLE_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // shared timer for the control lines, own timer for the emergency line
    rcpwm_counter u_grp_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_clear (|rise[N_GROUP-1:0]),
        .o_count (grp_count)
    );

    rcpwm_counter u_emg_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_clear (rise[LINE_EMG]),
        .o_count (emg_count)
    );

    // one capture lane per line
    for (genvar g = 0; g < N_LINES; g++) begin : g_lane
        rcpwm_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (accept),
            .i_level      (i_in_word.pin_levels[g]),
            .i_count      ((g == LINE_EMG) ? emg_count : grp_count),
            .o_rise       (rise[g]),
            .o_width_next (width_next[g])
        );
    end

    // conversion of the widths after this tick's latches
    rcpwm_merge u_merge (
        .i_widths (width_next),
        .i_cfg    (r_cfg),
        .o_word   (result)
    );

    // two-entry output buffer
    assign push        = accept & i_in_word.report;
    assign pop         = o_out_valid & ~i_out_stall;
    assign o_out_valid = (r_fill != 2'd0);
    assign o_in_stall  = (r_fill == 2'd2);
    assign o_out_word  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push)
                r_wr_ptr <= ~r_wr_ptr;
            if (pop)
                r_rd_ptr <= ~r_rd_ptr;
            if (push && !pop)
                r_fill <= r_fill + 2'd1;
            else if (pop && !push)
                r_fill <= r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_buf[r_wr_ptr] <= result;
    end

endmodule

/* rtl/rcpwm_lane.sv */
// ----------------------------------------------------------------------------
// rcpwm_lane
// One receiver line: edge detection against the previous level and capture
// of the running counter on a falling edge.
// ----------------------------------------------------------------------------
module rcpwm_lane
    import rcpwm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_level,
    input  t_count i_count,
    output logic   o_rise,
    output t_count o_width_next
);

    logic   r_prev;
    t_count r_width;
    logic   fall;

    // edges against last tick's level
    assign o_rise = i_level & ~r_prev;
    assign fall   = r_prev & ~i_level;

    // latch the counter as it stood before this tick's update
    assign o_width_next = fall ? i_count : r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_width <= '0;
        end else if (i_en) begin
            r_prev  <= i_level;
            r_width <= o_width_next;
        end
    end

endmodule

/* rtl/rcpwm_counter.sv */
// ----------------------------------------------------------------------------
// rcpwm_counter
// Saturating pulse timer, cleared on a rising edge of its line group.
// ----------------------------------------------------------------------------
module rcpwm_counter
    import rcpwm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_clear,
    output t_count o_count
);

    t_count r_count;
    t_count n_count;

    // clear wins, otherwise count up and stick at full scale
    always_comb begin
        if (i_clear)
            n_count = '0;
        else if (r_count == {CNT_W{1'b1}})
            n_count = r_count;
        else
            n_count = r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

/* rtl/rcpwm_merge.sv */
// ----------------------------------------------------------------------------
// rcpwm_merge
// Combines the lane widths into one result word: centred angles, scaled
// thrust and the emergency code with failsafe forcing.
// ----------------------------------------------------------------------------
module rcpwm_merge
    import rcpwm_pkg::*;
(
    input  t_widths   i_widths,
    input  t_cfg      i_cfg,
    output t_out_word o_word
);

    logic [ANGLE_W-1:0]  s_roll;
    logic [ANGLE_W-1:0]  s_pitch;
    logic [ANGLE_W-1:0]  s_yaw;
    logic [THRUST_W-1:0] s_thr;
    logic                fs_active;
    logic                brake;

    assign s_roll  = sat_angle(i_widths[LINE_ROLL]);
    assign s_pitch = sat_angle(i_widths[LINE_PITCH]);
    assign s_yaw   = sat_angle(i_widths[LINE_YAW]);
    assign s_thr   = sat_thrust(i_widths[LINE_THRUST]);

    // emergency width against both thresholds
    assign fs_active = CMP_W'(i_widths[LINE_EMG]) > CMP_W'(i_cfg.fs_thr);
    assign brake     = CMP_W'(i_widths[LINE_EMG]) > CMP_W'(i_cfg.brake_thr);

    // centre the angles, apply failsafe forcing
    always_comb begin
        if (fs_active) begin
            o_word.roll_angle  = '0;
            o_word.pitch_angle = '0;
            o_word.yaw_angle   = '0;
            o_word.thrust_out  = i_cfg.fs_thrust;
        end else begin
            o_word.roll_angle  = $signed({1'b0, s_roll}  - {1'b0, i_cfg.ang_ofs});
            o_word.pitch_angle = $signed({1'b0, s_pitch} - {1'b0, i_cfg.ang_ofs});
            o_word.yaw_angle   = $signed({1'b0, s_yaw}   - {1'b0, i_cfg.ang_ofs});
            o_word.thrust_out  = s_thr;
        end
        if (brake)
            o_word.emergency_code = EMG_BRAKE;
        else if (fs_active)
            o_word.emergency_code = EMG_FAILSAFE;
        else
            o_word.emergency_code = EMG_NORMAL;
    end

endmodule
